// ----- rtl/core/priority_message_queue_defines.svh -----
// Assertion macros for the priority message queue checker.
// Depends on nothing; the asserting module supplies signals named clock and reset.
`ifndef PRIORITY_MESSAGE_QUEUE_DEFINES_SVH
`define PRIORITY_MESSAGE_QUEUE_DEFINES_SVH

// Check that cons holds in the same cycle as ante.
`define PMQ_ASSERT_IMPLY(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pmq: same-cycle check failed");

// Check that cons holds in the cycle after ante.
`define PMQ_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pmq: next-cycle check failed");

`endif

// ----- rtl/core/pmq_pkg.sv -----
// Shared constants, types and helpers of the priority message queue.
// Used by the link store, the top level and the checker; depends on nothing.
package pmq_pkg;

   // Sizing
   localparam int SLOTS     = 16;
   localparam int QUEUES    = 4;
   localparam int MAX_PRIO  = 31;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int LINK_W    = $clog2(SLOTS + 1);
   localparam int QIDX_W    = $clog2(QUEUES);
   localparam int ADDR_W    = QIDX_W + SLOT_W;
   localparam int DEPTH     = QUEUES * SLOTS;
   localparam int CNT_W     = LINK_W;
   localparam int PRIO_W    = $clog2(MAX_PRIO + 1);
   localparam int IN_PRIO_W = 6;
   localparam int LEN_W     = 4;
   localparam int PAY_W     = 64;
   localparam int MAX_BYTES = 8;
   localparam int CSR_W     = 5;
   localparam int CSR_IDX_W = 1;

   // Link value that marks the end of a list
   localparam logic [LINK_W-1:0] NIL_SLOT = LINK_W'(SLOTS);

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_TOO_LONG = 3'd1,
      ST_BAD_PRIO = 3'd2,
      ST_FULL     = 3'd3,
      ST_EMPTY    = 3'd4
   } status_type;

   typedef enum logic {
      CMD_SEND = 1'b0,
      CMD_RECV = 1'b1
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_LENGTH = 1'b0,
      CSR_CAPACITY   = 1'b1
   } csr_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_ALLOC,
      S_WALK,
      S_LINK_PREV,
      S_LINK_SLOT,
      S_RECV,
      S_DONE
   } state_type;

   // Contents of one message slot
   typedef struct packed {
      logic [PAY_W-1:0]  payload;
      logic [LEN_W-1:0]  length;
      logic [PRIO_W-1:0] prio;
   } slot_data_type;

   // Access to the link store for one cycle
   typedef struct packed {
      logic [ADDR_W-1:0] rd_addr;
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic [LINK_W-1:0] wr_data;
   } link_req_type;

   // Keep the low len bytes of a payload, zero the rest
   function automatic logic [PAY_W-1:0] mask_payload(input logic [PAY_W-1:0] pay,
                                                     input logic [LEN_W-1:0] len);
      logic [PAY_W-1:0] m;
      m = '0;
      for (int b = 0; b < MAX_BYTES; b++) begin
         if (LEN_W'(b) < len) begin
            m[b*8 +: 8] = pay[b*8 +: 8];
         end
      end
      return m;
   endfunction

endpackage

// ----- rtl/core/pmq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module pmq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write one word, read one word each cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/pmq_link_store.sv -----
// Slot link store: a RAM plus one valid bit per entry, so that an entry
// never written reads as its free-chain reset value. Uses pmq_pkg and pmq_ram.
module pmq_link_store (
   input  logic                       clock,
   input  logic                       reset,
   input  pmq_pkg::link_req_type      req,
   output logic [pmq_pkg::LINK_W-1:0] rd_link
);

   logic [pmq_pkg::DEPTH-1:0]  valid_ff;
   logic [pmq_pkg::DEPTH-1:0]  valid_in;
   logic                       valid_rd_ff;
   logic [pmq_pkg::SLOT_W-1:0] slot_rd_ff;
   logic [pmq_pkg::LINK_W-1:0] ram_rd;
   logic [pmq_pkg::LINK_W-1:0] reset_link;

   pmq_ram #(
      .WIDTH(pmq_pkg::LINK_W),
      .DEPTH(pmq_pkg::DEPTH)
   ) u_link_ram (
      .clock  (clock),
      .rd_addr(req.rd_addr),
      .rd_data(ram_rd),
      .wr_en  (req.wr_en),
      .wr_addr(req.wr_addr),
      .wr_data(req.wr_data)
   );

   // Mark written entries
   always_comb begin
      valid_in = valid_ff;
      if (req.wr_en) begin
         valid_in[req.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Track valid bit and slot of the word in flight
   always_ff @(posedge clock) begin
      valid_rd_ff <= valid_ff[req.rd_addr];
      slot_rd_ff  <= req.rd_addr[pmq_pkg::SLOT_W-1:0];
   end

   // Unwritten entry chains to the next slot
   assign reset_link = pmq_pkg::LINK_W'(slot_rd_ff) + pmq_pkg::LINK_W'(1);
   assign rd_link    = valid_rd_ff ? ram_rd : reset_link;

endmodule

// ----- rtl/core/priority_message_queue.sv -----
// Top level of the priority message queue: sequencer, per-queue list heads,
// slot data RAM and link store. Uses pmq_pkg, pmq_ram and pmq_link_store.
//
//   channel  direction  handshake            word
//   req      in         req_valid/req_stall  cmd, queue, payload, length, priority
//   rsp      out        rsp_valid/rsp_stall  status, payload, length, priority, count
//   csr      in         csr_wen              register index and write data
//
// A send steps through check, alloc, walk, link-prev, link-slot and done; the walk
// length is the queued entries of equal or higher priority, plus one when a
// lower-priority entry follows them (at most SLOTS - 1 in all). The ordered list is
// walked one entry per cycle through the registered read port of the slot RAM and
// link store. A receive steps through check, recv and done, an error through check
// and done. Reset is synchronous; the block is ready in the first cycle after it.
// A stalled result holds in the output register; the next word may be taken
// meanwhile, and its result waits until the register frees up.
module priority_message_queue (
   input  logic                          clock,
   input  logic                          reset,

   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_cmd,
   input  logic [1:0]                    req_queue_id,
   input  logic [pmq_pkg::PAY_W-1:0]     req_payload,
   input  logic [pmq_pkg::LEN_W-1:0]     req_length,
   input  logic [pmq_pkg::IN_PRIO_W-1:0] req_priority_req,

   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_status,
   output logic [pmq_pkg::PAY_W-1:0]     rsp_out_payload,
   output logic [pmq_pkg::LEN_W-1:0]     rsp_out_length,
   output logic [pmq_pkg::PRIO_W-1:0]    rsp_out_priority,
   output logic [pmq_pkg::CNT_W-1:0]     rsp_queued_count,

   input  logic                          csr_wen,
   input  logic [pmq_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pmq_pkg::CSR_W-1:0]     csr_wdata
);

   // Sequencer and request registers
   pmq_pkg::state_type             state_ff, state_in;
   pmq_pkg::cmd_type               cmd_ff, cmd_in;
   logic [pmq_pkg::QIDX_W-1:0]     q_ff, q_in;
   logic [pmq_pkg::PAY_W-1:0]      pay_ff, pay_in;
   logic [pmq_pkg::LEN_W-1:0]      len_ff, len_in;
   logic [pmq_pkg::IN_PRIO_W-1:0]  prio_ff, prio_in;
   logic [pmq_pkg::SLOT_W-1:0]     slot_ff, slot_in;
   logic [pmq_pkg::LINK_W-1:0]     prev_ff, prev_in;
   logic [pmq_pkg::LINK_W-1:0]     cur_ff, cur_in;

   // Per-queue list state
   logic [pmq_pkg::LINK_W-1:0]     head_ff  [pmq_pkg::QUEUES];
   logic [pmq_pkg::LINK_W-1:0]     head_in  [pmq_pkg::QUEUES];
   logic [pmq_pkg::LINK_W-1:0]     free_ff  [pmq_pkg::QUEUES];
   logic [pmq_pkg::LINK_W-1:0]     free_in  [pmq_pkg::QUEUES];
   logic [pmq_pkg::CNT_W-1:0]      count_ff [pmq_pkg::QUEUES];
   logic [pmq_pkg::CNT_W-1:0]      count_in [pmq_pkg::QUEUES];

   // Configuration
   logic [pmq_pkg::LEN_W-1:0]      max_length_ff, max_length_in;
   logic [pmq_pkg::CNT_W-1:0]      capacity_ff, capacity_in;

   // Pending result
   pmq_pkg::status_type            res_status_ff, res_status_in;
   logic [pmq_pkg::PAY_W-1:0]      res_pay_ff, res_pay_in;
   logic [pmq_pkg::LEN_W-1:0]      res_len_ff, res_len_in;
   logic [pmq_pkg::PRIO_W-1:0]     res_prio_ff, res_prio_in;
   logic [pmq_pkg::CNT_W-1:0]      res_count_ff, res_count_in;

   // Output register
   logic                           rsp_valid_ff, rsp_valid_in;
   pmq_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [pmq_pkg::PAY_W-1:0]      rsp_pay_ff, rsp_pay_in;
   logic [pmq_pkg::LEN_W-1:0]      rsp_len_ff, rsp_len_in;
   logic [pmq_pkg::PRIO_W-1:0]     rsp_prio_ff, rsp_prio_in;
   logic [pmq_pkg::CNT_W-1:0]      rsp_count_ff, rsp_count_in;

   // Memory access
   pmq_pkg::link_req_type          link_req;
   logic [pmq_pkg::LINK_W-1:0]     link_rd;
   logic [pmq_pkg::ADDR_W-1:0]     data_rd_addr;
   pmq_pkg::slot_data_type         data_rd;
   logic                           data_wr_en;
   logic [pmq_pkg::ADDR_W-1:0]     data_wr_addr;
   pmq_pkg::slot_data_type         data_wr;

   // Views of the addressed queue
   logic [pmq_pkg::LINK_W-1:0]     head_q;
   logic [pmq_pkg::LINK_W-1:0]     free_q;
   logic [pmq_pkg::CNT_W-1:0]      count_q;
   logic [pmq_pkg::CNT_W-1:0]      cap_eff;
   logic                           len_bad;
   logic                           prio_bad;
   logic                           is_full;

   pmq_ram #(
      .WIDTH($bits(pmq_pkg::slot_data_type)),
      .DEPTH(pmq_pkg::DEPTH)
   ) u_data_ram (
      .clock  (clock),
      .rd_addr(data_rd_addr),
      .rd_data(data_rd),
      .wr_en  (data_wr_en),
      .wr_addr(data_wr_addr),
      .wr_data(data_wr)
   );

   pmq_link_store u_link_store (
      .clock  (clock),
      .reset  (reset),
      .req    (link_req),
      .rd_link(link_rd)
   );

   assign head_q  = head_ff[q_ff];
   assign free_q  = free_ff[q_ff];
   assign count_q = count_ff[q_ff];

   // Error checks on the held request
   assign cap_eff  = (capacity_ff > pmq_pkg::CNT_W'(pmq_pkg::SLOTS)) ?
                     pmq_pkg::CNT_W'(pmq_pkg::SLOTS) : capacity_ff;
   assign len_bad  = (len_ff > max_length_ff) ||
                     (len_ff > pmq_pkg::LEN_W'(pmq_pkg::MAX_BYTES));
   assign prio_bad = prio_ff > pmq_pkg::IN_PRIO_W'(pmq_pkg::MAX_PRIO);
   assign is_full  = (count_q >= cap_eff) || (free_q == pmq_pkg::NIL_SLOT);

   // Configuration writes
   always_comb begin
      max_length_in = max_length_ff;
      capacity_in   = capacity_ff;
      if (csr_wen) begin
         unique case (csr_index)
            pmq_pkg::CSR_MAX_LENGTH: max_length_in = csr_wdata[pmq_pkg::LEN_W-1:0];
            pmq_pkg::CSR_CAPACITY:   capacity_in   = csr_wdata[pmq_pkg::CNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer: next state, memory access and result
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      q_in          = q_ff;
      pay_in        = pay_ff;
      len_in        = len_ff;
      prio_in       = prio_ff;
      slot_in       = slot_ff;
      prev_in       = prev_ff;
      cur_in        = cur_ff;
      head_in       = head_ff;
      free_in       = free_ff;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_pay_in    = res_pay_ff;
      res_len_in    = res_len_ff;
      res_prio_in   = res_prio_ff;
      res_count_in  = res_count_ff;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_pay_in    = rsp_pay_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_count_in  = rsp_count_ff;

      link_req.rd_addr = {q_ff, cur_ff[pmq_pkg::SLOT_W-1:0]};
      link_req.wr_en   = 1'b0;
      link_req.wr_addr = {q_ff, slot_ff};
      link_req.wr_data = cur_ff;
      data_rd_addr     = {q_ff, cur_ff[pmq_pkg::SLOT_W-1:0]};
      data_wr_en       = 1'b0;
      data_wr_addr     = {q_ff, slot_ff};
      data_wr.payload  = pmq_pkg::mask_payload(pay_ff, len_ff);
      data_wr.length   = len_ff;
      data_wr.prio     = prio_ff[pmq_pkg::PRIO_W-1:0];

      unique case (state_ff)
         // Take a request word
         pmq_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd_in   = pmq_pkg::cmd_type'(req_cmd);
               q_in     = pmq_pkg::QIDX_W'(req_queue_id % pmq_pkg::QUEUES);
               pay_in   = req_payload;
               len_in   = req_length;
               prio_in  = req_priority_req;
               state_in = pmq_pkg::S_CHECK;
            end
         end

         // Report errors, otherwise read the slot to allocate or to pop
         pmq_pkg::S_CHECK: begin
            res_pay_in   = '0;
            res_len_in   = '0;
            res_prio_in  = '0;
            res_count_in = count_q;
            if (len_bad) begin
               res_status_in = pmq_pkg::ST_TOO_LONG;
               state_in      = pmq_pkg::S_DONE;
            end else if (cmd_ff == pmq_pkg::CMD_SEND) begin
               if (prio_bad) begin
                  res_status_in = pmq_pkg::ST_BAD_PRIO;
                  state_in      = pmq_pkg::S_DONE;
               end else if (is_full) begin
                  res_status_in = pmq_pkg::ST_FULL;
                  state_in      = pmq_pkg::S_DONE;
               end else begin
                  slot_in          = free_q[pmq_pkg::SLOT_W-1:0];
                  link_req.rd_addr = {q_ff, free_q[pmq_pkg::SLOT_W-1:0]};
                  state_in         = pmq_pkg::S_ALLOC;
               end
            end else if (head_q == pmq_pkg::NIL_SLOT) begin
               res_status_in = pmq_pkg::ST_EMPTY;
               state_in      = pmq_pkg::S_DONE;
            end else begin
               slot_in          = head_q[pmq_pkg::SLOT_W-1:0];
               link_req.rd_addr = {q_ff, head_q[pmq_pkg::SLOT_W-1:0]};
               data_rd_addr     = {q_ff, head_q[pmq_pkg::SLOT_W-1:0]};
               state_in         = pmq_pkg::S_RECV;
            end
         end

         // Pop the free list, store the message, start the walk at the head
         pmq_pkg::S_ALLOC: begin
            free_in[q_ff]  = link_rd;
            count_in[q_ff] = count_q + pmq_pkg::CNT_W'(1);
            data_wr_en     = 1'b1;
            prev_in        = pmq_pkg::NIL_SLOT;
            cur_in         = head_q;
            link_req.rd_addr = {q_ff, head_q[pmq_pkg::SLOT_W-1:0]};
            data_rd_addr     = {q_ff, head_q[pmq_pkg::SLOT_W-1:0]};
            if (head_q == pmq_pkg::NIL_SLOT) begin
               state_in = pmq_pkg::S_LINK_PREV;
            end else begin
               state_in = pmq_pkg::S_WALK;
            end
         end

         // Advance past entries of equal or higher priority, one per cycle
         pmq_pkg::S_WALK: begin
            if (pmq_pkg::IN_PRIO_W'(data_rd.prio) >= prio_ff) begin
               prev_in          = cur_ff;
               cur_in           = link_rd;
               link_req.rd_addr = {q_ff, link_rd[pmq_pkg::SLOT_W-1:0]};
               data_rd_addr     = {q_ff, link_rd[pmq_pkg::SLOT_W-1:0]};
               if (link_rd == pmq_pkg::NIL_SLOT) begin
                  state_in = pmq_pkg::S_LINK_PREV;
               end
            end else begin
               state_in = pmq_pkg::S_LINK_PREV;
            end
         end

         // Point the predecessor (or the head) at the new slot
         pmq_pkg::S_LINK_PREV: begin
            if (prev_ff != pmq_pkg::NIL_SLOT) begin
               link_req.wr_en   = 1'b1;
               link_req.wr_addr = {q_ff, prev_ff[pmq_pkg::SLOT_W-1:0]};
               link_req.wr_data = pmq_pkg::LINK_W'(slot_ff);
            end else begin
               head_in[q_ff] = pmq_pkg::LINK_W'(slot_ff);
            end
            state_in = pmq_pkg::S_LINK_SLOT;
         end

         // Point the new slot at its successor
         pmq_pkg::S_LINK_SLOT: begin
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = {q_ff, slot_ff};
            link_req.wr_data = cur_ff;
            res_status_in    = pmq_pkg::ST_OK;
            res_pay_in       = '0;
            res_len_in       = '0;
            res_prio_in      = '0;
            res_count_in     = count_q;
            state_in         = pmq_pkg::S_DONE;
         end

         // Unlink the head and push it on the free list
         pmq_pkg::S_RECV: begin
            head_in[q_ff]    = link_rd;
            link_req.wr_en   = 1'b1;
            link_req.wr_addr = {q_ff, slot_ff};
            link_req.wr_data = free_q;
            free_in[q_ff]    = pmq_pkg::LINK_W'(slot_ff);
            res_count_in     = count_q;
            if (count_q != '0) begin
               count_in[q_ff] = count_q - pmq_pkg::CNT_W'(1);
               res_count_in   = count_q - pmq_pkg::CNT_W'(1);
            end
            res_status_in = pmq_pkg::ST_OK;
            res_pay_in    = data_rd.payload;
            res_len_in    = data_rd.length;
            res_prio_in   = data_rd.prio;
            state_in      = pmq_pkg::S_DONE;
         end

         // Hand the result to the output register once it is free
         pmq_pkg::S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_pay_in    = res_pay_ff;
               rsp_len_in    = res_len_ff;
               rsp_prio_in   = res_prio_ff;
               rsp_count_in  = res_count_ff;
               state_in      = pmq_pkg::S_IDLE;
            end
         end

         default: state_in = pmq_pkg::S_IDLE;
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= pmq_pkg::S_IDLE;
         rsp_valid_ff  <= 1'b0;
         max_length_ff <= pmq_pkg::LEN_W'(pmq_pkg::MAX_BYTES);
         capacity_ff   <= pmq_pkg::CNT_W'(pmq_pkg::SLOTS);
         for (int i = 0; i < pmq_pkg::QUEUES; i++) begin
            head_ff[i]  <= pmq_pkg::NIL_SLOT;
            free_ff[i]  <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         max_length_ff <= max_length_in;
         capacity_ff   <= capacity_in;
         head_ff       <= head_in;
         free_ff       <= free_in;
         count_ff      <= count_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      q_ff          <= q_in;
      pay_ff        <= pay_in;
      len_ff        <= len_in;
      prio_ff       <= prio_in;
      slot_ff       <= slot_in;
      prev_ff       <= prev_in;
      cur_ff        <= cur_in;
      res_status_ff <= res_status_in;
      res_pay_ff    <= res_pay_in;
      res_len_ff    <= res_len_in;
      res_prio_ff   <= res_prio_in;
      res_count_ff  <= res_count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pay_ff    <= rsp_pay_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign req_stall        = (state_ff != pmq_pkg::S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_payload  = rsp_pay_ff;
   assign rsp_out_length   = rsp_len_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_queued_count = rsp_count_ff;

endmodule

// ----- rtl/core/pmq_checker.sv -----
// Port-level checks of the priority message queue, bound to the top level.
// Uses pmq_pkg and the macros of priority_message_queue_defines.svh.
`include "priority_message_queue_defines.svh"

module pmq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [2:0]                    rsp_status,
   input logic [pmq_pkg::PAY_W-1:0]     rsp_out_payload,
   input logic [pmq_pkg::LEN_W-1:0]     rsp_out_length,
   input logic [pmq_pkg::PRIO_W-1:0]    rsp_out_priority,
   input logic [pmq_pkg::CNT_W-1:0]     rsp_queued_count
);

   // Hold a stalled result word
   `PMQ_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid)

   // Go busy right after taking a request word
   `PMQ_ASSERT_NEXT(a_busy_after_accept, req_valid && !req_stall, req_stall)

   // Zero the message fields of every error result
   `PMQ_ASSERT_IMPLY(a_error_zero, rsp_valid && (rsp_status != pmq_pkg::ST_OK), (rsp_out_payload == '0) && (rsp_out_length == '0) && (rsp_out_priority == '0))

   // An empty queue holds no messages
   `PMQ_ASSERT_IMPLY(a_empty_count, rsp_valid && (rsp_status == pmq_pkg::ST_EMPTY), rsp_queued_count == '0)

endmodule

bind priority_message_queue pmq_checker u_pmq_checker (.*);
